/* rtl/tpcal_pkg.sv */
// types, constants and control store of the two point touch calibrator
package tpcal_pkg;

    localparam int SAMPLES_PER_CORNER = 3;

    localparam int RAW_W    = 12;
    localparam int RES_W    = 12;
    localparam int INSET_W  = 10;
    localparam int CNT_W    = 5;
    localparam int SUM_W    = 17;
    localparam int GAIN_W   = 16;
    localparam int OFF_W    = 32;
    localparam int OUT_W    = 16;
    localparam int PROD_W   = GAIN_W + RAW_W + 1;
    localparam int DIFF_W   = RES_W + 2;
    localparam int NUM_W    = DIFF_W + 11;
    localparam int KINS_W   = INSET_W + 10;
    localparam int T_W      = 34;
    localparam int D_W      = RAW_W + 1;
    localparam int DIV_W    = 34;
    localparam int Q_W      = DIV_W + 1;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DCNT_W   = $clog2(DIV_STEPS + 1);
    localparam int PC_W     = 5;

    localparam logic [9:0] SCALE = 10'd1000;

    localparam logic [1:0] PH_TOP_LEFT     = 2'd0;
    localparam logic [1:0] PH_BOTTOM_RIGHT = 2'd1;
    localparam logic [1:0] PH_WAIT_LEAVE   = 2'd2;
    localparam logic [1:0] PH_READY        = 2'd3;

    localparam logic [1:0] REG_HOR_RES      = 2'd0;
    localparam logic [1:0] REG_VER_RES      = 2'd1;
    localparam logic [1:0] REG_TARGET_INSET = 2'd2;

    localparam logic [PC_W-1:0] A_FETCH    = 5'd0;
    localparam logic [PC_W-1:0] A_DISPATCH = 5'd1;
    localparam logic [PC_W-1:0] A_MAP      = 5'd10;
    localparam logic [PC_W-1:0] A_SOLVE    = 5'd14;
    localparam logic [PC_W-1:0] A_ERR      = 5'd21;
    localparam logic [PC_W-1:0] A_EMIT     = 5'd22;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_ACC,
        OP_LD_SUMX,
        OP_LD_SUMY,
        OP_LD_MAPX,
        OP_LD_MAPY,
        OP_LD_NUMX,
        OP_LD_NUMY,
        OP_LD_OFFX,
        OP_LD_OFFY,
        OP_DIV,
        OP_ERR,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_ALWAYS,
        C_POLL_PRESSED,
        C_POLL,
        C_READY,
        C_WAIT,
        C_COUNT_SHORT,
        C_SPAN_ZERO
    } t_cond;

    typedef enum logic [2:0] {
        D_NONE,
        D_CORNX,
        D_CORNY,
        D_HELDX,
        D_HELDY,
        D_GAINX,
        D_GAINY
    } t_dest;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        t_dest           dest;
        logic [PC_W-1:0] target;
    } t_uword;

    function automatic t_uword rom_word(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            5'd0:  w = '{OP_FETCH,   C_NONE,         D_NONE,  A_FETCH};
            5'd1:  w = '{OP_NOP,     C_POLL_PRESSED, D_NONE,  A_MAP};
            5'd2:  w = '{OP_NOP,     C_POLL,         D_NONE,  A_EMIT};
            5'd3:  w = '{OP_NOP,     C_READY,        D_NONE,  A_EMIT};
            5'd4:  w = '{OP_NOP,     C_WAIT,         D_NONE,  A_SOLVE};
            5'd5:  w = '{OP_ACC,     C_COUNT_SHORT,  D_NONE,  A_EMIT};
            5'd6:  w = '{OP_LD_SUMX, C_NONE,         D_NONE,  A_FETCH};
            5'd7:  w = '{OP_DIV,     C_NONE,         D_CORNX, A_FETCH};
            5'd8:  w = '{OP_LD_SUMY, C_NONE,         D_NONE,  A_FETCH};
            5'd9:  w = '{OP_DIV,     C_ALWAYS,       D_CORNY, A_EMIT};
            5'd10: w = '{OP_LD_MAPX, C_NONE,         D_NONE,  A_FETCH};
            5'd11: w = '{OP_DIV,     C_NONE,         D_HELDX, A_FETCH};
            5'd12: w = '{OP_LD_MAPY, C_NONE,         D_NONE,  A_FETCH};
            5'd13: w = '{OP_DIV,     C_ALWAYS,       D_HELDY, A_EMIT};
            5'd14: w = '{OP_NOP,     C_SPAN_ZERO,    D_NONE,  A_ERR};
            5'd15: w = '{OP_LD_NUMX, C_NONE,         D_NONE,  A_FETCH};
            5'd16: w = '{OP_DIV,     C_NONE,         D_GAINX, A_FETCH};
            5'd17: w = '{OP_LD_OFFX, C_NONE,         D_NONE,  A_FETCH};
            5'd18: w = '{OP_LD_NUMY, C_NONE,         D_NONE,  A_FETCH};
            5'd19: w = '{OP_DIV,     C_NONE,         D_GAINY, A_FETCH};
            5'd20: w = '{OP_LD_OFFY, C_ALWAYS,       D_NONE,  A_EMIT};
            5'd21: w = '{OP_ERR,     C_NONE,         D_NONE,  A_FETCH};
            5'd22: w = '{OP_EMIT,    C_ALWAYS,       D_NONE,  A_FETCH};
            default: w = '{OP_NOP,   C_ALWAYS,       D_NONE,  A_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat16(input logic signed [Q_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > Q_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < Q_W'(-32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/touch_two_point_calibration.sv */
// two point touch calibrator top level: microcoded sequencer and datapath
//
// Each transaction on the input channel gives exactly one result transaction. Items are
// handled one at a time by a microcode sequencer that owns a shared signed divider retiring
// two quotient bits per cycle over a 34 bit dividend (17 iterations plus load and writeback).
// A pressed scan poll runs one division per axis; the click that solves the calibration runs
// two divisions, and the click that closes a corner two divisions by the sample count. The
// click that meets a zero span, released polls, ignored clicks and accumulating clicks use no
// division. A finished result waits in an output register, so the next item is taken while
// it is still stalled.
// The configuration port is always ready and must only be written while the block is idle.
module touch_two_point_calibration (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_cmd,
    input  logic                                   i_is_pressed,
    input  logic [tpcal_pkg::RAW_W-1:0]            i_raw_x,
    input  logic [tpcal_pkg::RAW_W-1:0]            i_raw_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [tpcal_pkg::OUT_W-1:0]     o_out_x,
    output logic signed [tpcal_pkg::OUT_W-1:0]     o_out_y,
    output logic                                   o_out_pressed,
    output logic [1:0]                             o_phase,
    output logic                                   o_calib_error,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [1:0]                             i_cfg_index,
    input  logic [tpcal_pkg::RES_W-1:0]            i_cfg_data
);

    // configuration
    logic [tpcal_pkg::RES_W-1:0]            r_hor_res;
    logic [tpcal_pkg::RES_W-1:0]            r_ver_res;
    logic [tpcal_pkg::INSET_W-1:0]          r_inset;

    // calibration state
    logic [1:0]                             r_phase;
    logic [tpcal_pkg::CNT_W-1:0]            r_count;
    logic [tpcal_pkg::SUM_W-1:0]            r_sum_x;
    logic [tpcal_pkg::SUM_W-1:0]            r_sum_y;
    logic [tpcal_pkg::RAW_W-1:0]            r_corner_x [2];
    logic [tpcal_pkg::RAW_W-1:0]            r_corner_y [2];
    logic signed [tpcal_pkg::GAIN_W-1:0]    r_gain_x;
    logic signed [tpcal_pkg::GAIN_W-1:0]    r_gain_y;
    logic signed [tpcal_pkg::OFF_W-1:0]     r_off_x;
    logic signed [tpcal_pkg::OFF_W-1:0]     r_off_y;
    logic signed [tpcal_pkg::OUT_W-1:0]     r_held_x;
    logic signed [tpcal_pkg::OUT_W-1:0]     r_held_y;

    // current item
    logic                                   r_cmd;
    logic                                   r_press;
    logic [tpcal_pkg::RAW_W-1:0]            r_raw_x;
    logic [tpcal_pkg::RAW_W-1:0]            r_raw_y;
    logic                                   r_err;

    // sequencer and divider
    logic [tpcal_pkg::PC_W-1:0]             r_pc;
    logic [tpcal_pkg::PC_W-1:0]             n_pc;
    logic signed [tpcal_pkg::T_W-1:0]       r_t;
    logic signed [tpcal_pkg::D_W-1:0]       r_d;
    logic                                   r_run;
    logic [tpcal_pkg::DCNT_W-1:0]           r_dcnt;
    logic [tpcal_pkg::DIV_W-1:0]            r_quo;
    logic [tpcal_pkg::DIV_W-1:0]            n_quo;
    logic [tpcal_pkg::RAW_W-1:0]            r_rem;
    logic [tpcal_pkg::RAW_W-1:0]            n_rem;
    logic [tpcal_pkg::RAW_W-1:0]            r_dvs;
    logic                                   r_neg;

    // output register
    logic                                   r_o_valid;
    logic signed [tpcal_pkg::OUT_W-1:0]     r_o_x;
    logic signed [tpcal_pkg::OUT_W-1:0]     r_o_y;
    logic                                   r_o_pressed;
    logic [1:0]                             r_o_phase;
    logic                                   r_o_err;

    tpcal_pkg::t_uword                      w;
    logic                                   jump;
    logic                                   done;
    logic                                   span_zero;
    logic                                   sel_y;

    logic signed [tpcal_pkg::GAIN_W-1:0]    mul_g;
    logic [tpcal_pkg::RAW_W-1:0]            mul_r;
    logic signed [tpcal_pkg::PROD_W-1:0]    prod;
    logic signed [tpcal_pkg::OFF_W-1:0]     off_sel;
    logic signed [tpcal_pkg::T_W-1:0]       map_t;
    logic [tpcal_pkg::RES_W-1:0]            res_sel;
    logic signed [tpcal_pkg::DIFF_W-1:0]    diff;
    logic signed [tpcal_pkg::NUM_W-1:0]     num;
    logic signed [tpcal_pkg::D_W-1:0]       span_sel;
    logic [tpcal_pkg::KINS_W-1:0]           inset_k;
    logic signed [tpcal_pkg::T_W-1:0]       off_new;

    logic [tpcal_pkg::T_W-1:0]              abs_t;
    logic [tpcal_pkg::D_W-1:0]              abs_d;
    logic [tpcal_pkg::RAW_W:0]              trial1;
    logic [tpcal_pkg::RAW_W:0]              trial2;
    logic                                   ge1;
    logic                                   ge2;
    logic [tpcal_pkg::RAW_W-1:0]            rem1;
    logic signed [tpcal_pkg::Q_W-1:0]       q_signed;
    logic signed [tpcal_pkg::OUT_W-1:0]     q_sat;

    assign w = tpcal_pkg::rom_word(r_pc);

    assign span_zero = (r_corner_x[1] == r_corner_x[0]) || (r_corner_y[1] == r_corner_y[0]);

    always_comb begin
        case (w.cond)
            tpcal_pkg::C_NONE:         jump = 1'b0;
            tpcal_pkg::C_ALWAYS:       jump = 1'b1;
            tpcal_pkg::C_POLL_PRESSED: jump = r_cmd && r_press;
            tpcal_pkg::C_POLL:         jump = r_cmd;
            tpcal_pkg::C_READY:        jump = (r_phase == tpcal_pkg::PH_READY);
            tpcal_pkg::C_WAIT:         jump = (r_phase == tpcal_pkg::PH_WAIT_LEAVE);
            tpcal_pkg::C_COUNT_SHORT:
                jump = (r_count < tpcal_pkg::CNT_W'(tpcal_pkg::SAMPLES_PER_CORNER - 1));
            tpcal_pkg::C_SPAN_ZERO:    jump = span_zero;
            default:                   jump = 1'b0;
        endcase
    end

    always_comb begin
        case (w.op)
            tpcal_pkg::OP_FETCH: done = i_valid;
            tpcal_pkg::OP_DIV:
                done = r_run && (r_dcnt == tpcal_pkg::DCNT_W'(tpcal_pkg::DIV_STEPS));
            tpcal_pkg::OP_EMIT:  done = !r_o_valid || !i_stall;
            default:             done = 1'b1;
        endcase
    end

    always_comb begin
        if (!done) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = w.target;
        end else begin
            n_pc = r_pc + tpcal_pkg::PC_W'(1);
        end
    end

    // shared multiplier and operand selection
    assign sel_y = (w.op == tpcal_pkg::OP_LD_MAPY) || (w.op == tpcal_pkg::OP_LD_OFFY)
                || (w.op == tpcal_pkg::OP_LD_NUMY);

    always_comb begin
        case (w.op)
            tpcal_pkg::OP_LD_MAPX: mul_r = r_raw_x;
            tpcal_pkg::OP_LD_MAPY: mul_r = r_raw_y;
            tpcal_pkg::OP_LD_OFFX: mul_r = r_corner_x[0];
            tpcal_pkg::OP_LD_OFFY: mul_r = r_corner_y[0];
            default:               mul_r = r_raw_x;
        endcase
    end

    assign mul_g    = sel_y ? r_gain_y : r_gain_x;
    assign off_sel  = sel_y ? r_off_y : r_off_x;
    assign prod     = tpcal_pkg::PROD_W'(mul_g) * tpcal_pkg::PROD_W'($signed({1'b0, mul_r}));
    assign map_t    = tpcal_pkg::T_W'(prod) + tpcal_pkg::T_W'(off_sel);

    assign res_sel  = sel_y ? r_ver_res : r_hor_res;
    assign diff     = $signed({2'b00, res_sel}) - $signed({3'b000, r_inset, 1'b0});
    assign num      = tpcal_pkg::NUM_W'(diff)
                    * tpcal_pkg::NUM_W'($signed({1'b0, tpcal_pkg::SCALE}));
    assign span_sel = sel_y ? ($signed({1'b0, r_corner_y[1]}) - $signed({1'b0, r_corner_y[0]}))
                            : ($signed({1'b0, r_corner_x[1]}) - $signed({1'b0, r_corner_x[0]}));

    assign inset_k  = tpcal_pkg::KINS_W'(r_inset) * tpcal_pkg::KINS_W'(tpcal_pkg::SCALE);
    assign off_new  = tpcal_pkg::T_W'($signed({1'b0, inset_k})) - tpcal_pkg::T_W'(prod);

    // divider: magnitudes, two restoring steps per cycle
    assign abs_t = r_t[tpcal_pkg::T_W-1] ? tpcal_pkg::T_W'(-r_t) : tpcal_pkg::T_W'(r_t);
    assign abs_d = r_d[tpcal_pkg::D_W-1] ? tpcal_pkg::D_W'(-r_d) : tpcal_pkg::D_W'(r_d);

    assign trial1 = {r_rem, r_quo[tpcal_pkg::DIV_W-1]};
    assign ge1    = trial1 >= {1'b0, r_dvs};
    assign rem1   = ge1 ? tpcal_pkg::RAW_W'(trial1 - {1'b0, r_dvs})
                        : trial1[tpcal_pkg::RAW_W-1:0];
    assign trial2 = {rem1, r_quo[tpcal_pkg::DIV_W-2]};
    assign ge2    = trial2 >= {1'b0, r_dvs};
    assign n_rem  = ge2 ? tpcal_pkg::RAW_W'(trial2 - {1'b0, r_dvs})
                        : trial2[tpcal_pkg::RAW_W-1:0];
    assign n_quo  = {r_quo[tpcal_pkg::DIV_W-3:0], ge1, ge2};

    assign q_signed = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign q_sat    = tpcal_pkg::sat16(q_signed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hor_res     <= 12'd480;
            r_ver_res     <= 12'd272;
            r_inset       <= 10'd18;
            r_phase       <= tpcal_pkg::PH_TOP_LEFT;
            r_count       <= '0;
            r_sum_x       <= '0;
            r_sum_y       <= '0;
            r_corner_x[0] <= '0;
            r_corner_x[1] <= '0;
            r_corner_y[0] <= '0;
            r_corner_y[1] <= '0;
            r_gain_x      <= 16'sd1000;
            r_gain_y      <= 16'sd1000;
            r_off_x       <= '0;
            r_off_y       <= '0;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_err         <= 1'b0;
            r_pc          <= tpcal_pkg::A_FETCH;
            r_run         <= 1'b0;
            r_dcnt        <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            r_pc <= n_pc;

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tpcal_pkg::REG_HOR_RES:      r_hor_res <= i_cfg_data;
                    tpcal_pkg::REG_VER_RES:      r_ver_res <= i_cfg_data;
                    tpcal_pkg::REG_TARGET_INSET: r_inset   <= i_cfg_data[tpcal_pkg::INSET_W-1:0];
                    default: ;
                endcase
            end

            if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (w.op)
                tpcal_pkg::OP_FETCH: begin
                    if (i_valid) begin
                        r_cmd   <= i_cmd;
                        r_press <= i_is_pressed;
                        r_raw_x <= i_raw_x;
                        r_raw_y <= i_raw_y;
                        r_err   <= 1'b0;
                    end
                end
                tpcal_pkg::OP_ACC: begin
                    r_sum_x <= r_sum_x + tpcal_pkg::SUM_W'(r_raw_x);
                    r_sum_y <= r_sum_y + tpcal_pkg::SUM_W'(r_raw_y);
                    r_count <= r_count + tpcal_pkg::CNT_W'(1);
                end
                tpcal_pkg::OP_LD_SUMX: begin
                    r_t <= tpcal_pkg::T_W'(r_sum_x);
                    r_d <= tpcal_pkg::D_W'(tpcal_pkg::SAMPLES_PER_CORNER);
                end
                tpcal_pkg::OP_LD_SUMY: begin
                    r_t <= tpcal_pkg::T_W'(r_sum_y);
                    r_d <= tpcal_pkg::D_W'(tpcal_pkg::SAMPLES_PER_CORNER);
                end
                tpcal_pkg::OP_LD_MAPX, tpcal_pkg::OP_LD_MAPY: begin
                    r_t <= map_t;
                    r_d <= tpcal_pkg::D_W'(tpcal_pkg::SCALE);
                end
                tpcal_pkg::OP_LD_NUMX, tpcal_pkg::OP_LD_NUMY: begin
                    r_t <= tpcal_pkg::T_W'(num);
                    r_d <= span_sel;
                end
                tpcal_pkg::OP_LD_OFFX: begin
                    r_off_x <= off_new[tpcal_pkg::OFF_W-1:0];
                end
                tpcal_pkg::OP_LD_OFFY: begin
                    r_off_y <= off_new[tpcal_pkg::OFF_W-1:0];
                    r_phase <= tpcal_pkg::PH_READY;
                end
                tpcal_pkg::OP_DIV: begin
                    if (!r_run) begin
                        r_run  <= 1'b1;
                        r_dcnt <= '0;
                        r_quo  <= abs_t[tpcal_pkg::DIV_W-1:0];
                        r_rem  <= '0;
                        r_dvs  <= abs_d[tpcal_pkg::RAW_W-1:0];
                        r_neg  <= r_t[tpcal_pkg::T_W-1] ^ r_d[tpcal_pkg::D_W-1];
                    end else if (r_dcnt != tpcal_pkg::DCNT_W'(tpcal_pkg::DIV_STEPS)) begin
                        r_quo  <= n_quo;
                        r_rem  <= n_rem;
                        r_dcnt <= r_dcnt + tpcal_pkg::DCNT_W'(1);
                    end else begin
                        r_run <= 1'b0;
                        case (w.dest)
                            tpcal_pkg::D_CORNX: begin
                                r_corner_x[r_phase[0]] <= r_quo[tpcal_pkg::RAW_W-1:0];
                            end
                            tpcal_pkg::D_CORNY: begin
                                r_corner_y[r_phase[0]] <= r_quo[tpcal_pkg::RAW_W-1:0];
                                r_sum_x <= '0;
                                r_sum_y <= '0;
                                r_count <= '0;
                                r_phase <= (r_phase == tpcal_pkg::PH_TOP_LEFT)
                                         ? tpcal_pkg::PH_BOTTOM_RIGHT : tpcal_pkg::PH_WAIT_LEAVE;
                            end
                            tpcal_pkg::D_HELDX: r_held_x <= q_sat;
                            tpcal_pkg::D_HELDY: r_held_y <= q_sat;
                            tpcal_pkg::D_GAINX: r_gain_x <= q_sat;
                            tpcal_pkg::D_GAINY: r_gain_y <= q_sat;
                            default: ;
                        endcase
                    end
                end
                tpcal_pkg::OP_ERR: begin
                    r_err   <= 1'b1;
                    r_sum_x <= '0;
                    r_sum_y <= '0;
                    r_count <= '0;
                    r_phase <= tpcal_pkg::PH_TOP_LEFT;
                end
                tpcal_pkg::OP_EMIT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid   <= 1'b1;
                        r_o_x       <= r_held_x;
                        r_o_y       <= r_held_y;
                        r_o_pressed <= r_cmd && r_press;
                        r_o_phase   <= r_phase;
                        r_o_err     <= r_err;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_stall       = (w.op != tpcal_pkg::OP_FETCH);
    assign o_cfg_ready   = 1'b1;
    assign o_valid       = r_o_valid;
    assign o_out_x       = r_o_x;
    assign o_out_y       = r_o_y;
    assign o_out_pressed = r_o_pressed;
    assign o_phase       = r_o_phase;
    assign o_calib_error = r_o_err;

    a_err_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_calib_error) |-> (o_phase == tpcal_pkg::PH_TOP_LEFT))
        else $error("calibration error reported without restart");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w.op == tpcal_pkg::OP_DIV && !r_run) |-> (r_d != '0))
        else $error("divider started with zero divisor");

    a_fetch_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_pc == tpcal_pkg::A_DISPATCH))
        else $error("accepted transaction not dispatched");

    a_press_only_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w.op == tpcal_pkg::OP_EMIT && r_cmd == 1'b0) |-> !(r_cmd && r_press))
        else $error("click reported as pressed");

endmodule
